/* sv/mgdl_pkg.sv */
// Shared types, constants and tables for the month grid day lookup.
package mgdl_pkg;

  localparam int unsigned DaysInWeek = 7;
  localparam int unsigned GridCells  = 42;

  // Width of the data word on the write port: the widest register (year).
  localparam int unsigned CfgDataW = 14;

  // Year / 100 is taken as (year >> 2) / 25, with 1 / 25 ~= 1311 / 2^15.
  // Exact for (year >> 2) below 4681.
  localparam logic [10:0] Recip25    = 11'd1311;
  localparam int unsigned Recip25Shr = 15;

  typedef enum logic [1:0] {
    REG_SHOWN_MONTH = 2'd0,
    REG_SHOWN_YEAR  = 2'd1,
    REG_WEEK_START  = 2'd2
  } cfg_idx_t;

  // Configuration as seen by the datapath: month clamped to 1..12,
  // week start wrapped to 0..6.
  typedef struct packed {
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  week_start;
  } cfg_t;

  // Per-month values used by the later stages.
  typedef struct packed {
    logic [4:0]  len;
    logic [4:0]  prev_len;
    logic [14:0] dow_sum;
  } month_info_t;

  // Non-leap month length, month 1..12.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // Day-of-week shift of day 1 of month m, month 1..12.
  function automatic logic [2:0] dow_shift(input logic [3:0] m);
    logic [2:0] s;
    unique case (m)
      4'd1:  s = 3'd0;
      4'd2:  s = 3'd3;
      4'd3:  s = 3'd2;
      4'd4:  s = 3'd5;
      4'd5:  s = 3'd0;
      4'd6:  s = 3'd3;
      4'd7:  s = 3'd5;
      4'd8:  s = 3'd1;
      4'd9:  s = 3'd4;
      4'd10: s = 3'd6;
      4'd11: s = 3'd2;
      4'd12: s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

/* sv/mgdl_cfg_regs.sv */
// Configuration registers with month clamp and week-start wrap.
module mgdl_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [mgdl_pkg::CfgDataW-1:0]   cfg_wdata,
  output mgdl_pkg::cfg_t                  cfg
);

  logic [3:0]  month_r;
  logic [13:0] year_r;
  logic [2:0]  ws_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= 4'd1;
      year_r  <= 14'd2000;
      ws_r    <= 3'd1;
    end else if (cfg_we) begin
      unique case (mgdl_pkg::cfg_idx_t'(cfg_index))
        mgdl_pkg::REG_SHOWN_MONTH: month_r <= cfg_wdata[3:0];
        mgdl_pkg::REG_SHOWN_YEAR:  year_r  <= cfg_wdata[13:0];
        mgdl_pkg::REG_WEEK_START:  ws_r    <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.year = year_r;
    priority if (month_r == 4'd0) begin
      cfg.month = 4'd1;
    end else if (month_r > 4'd12) begin
      cfg.month = 4'd12;
    end else begin
      cfg.month = month_r;
    end
    cfg.week_start = (ws_r == 3'd7) ? 3'd0 : ws_r;
  end

endmodule

/* sv/mgdl_century_div.sv */
// Year / 100 by reciprocal multiplication.
module mgdl_century_div (
  input  logic [13:0] year,
  output logic [7:0]  q100
);

  logic [22:0] prod;

  assign prod = 23'(year[13:2]) * 23'(mgdl_pkg::Recip25);
  assign q100 = prod[mgdl_pkg::Recip25Shr +: 8];

endmodule

/* sv/mgdl_month_info.sv */
// Leap year, month lengths and the day-of-week sum of day 1.
module mgdl_month_info (
  input  mgdl_pkg::cfg_t        cfg,
  input  logic [7:0]            q100,
  output mgdl_pkg::month_info_t info
);

  logic        early;      // January or February count in the previous year
  logic [13:0] hund;
  logic [13:0] rem_full;
  logic        cent_zero;
  logic        leap;
  logic [3:0]  prev_m;
  logic [14:0] yy;
  logic [7:0]  yy_q100;
  logic [5:0]  yy_q400;

  always_comb begin
    early     = (cfg.month < 4'd3);
    hund      = 14'(q100) * 14'd100;
    rem_full  = cfg.year - hund;
    cent_zero = (rem_full[6:0] == 7'd0);
    leap      = ((cfg.year[1:0] == 2'd0) && !cent_zero) ||
                (cent_zero && (q100[1:0] == 2'd0));

    info.len = ((cfg.month == 4'd2) && leap) ? 5'd29 : mgdl_pkg::month_len(cfg.month);
    prev_m   = (cfg.month == 4'd1) ? 4'd12 : cfg.month - 4'd1;
    info.prev_len = ((prev_m == 4'd2) && leap) ? 5'd29 : mgdl_pkg::month_len(prev_m);

    // Shifted by 400 years to stay nonnegative; that is a whole number of weeks.
    yy      = {1'b0, cfg.year} + 15'd400 - {14'd0, early};
    yy_q100 = 8'd4 + q100 - {7'd0, early && cent_zero};
    yy_q400 = yy_q100[7:2];
    info.dow_sum = yy + {2'b00, yy[14:2]} - 15'(yy_q100) + 15'(yy_q400) +
                   15'(mgdl_pkg::dow_shift(cfg.month)) + 15'd1;
  end

endmodule

/* sv/mgdl_lead_offset.sv */
// Weekday of day 1 (mod 7 by octal digit folding) and the leading offset.
module mgdl_lead_offset (
  input  logic [14:0] dow_sum,
  input  logic [2:0]  week_start,
  output logic [2:0]  offset
);

  logic [5:0] fold1;
  logic [3:0] fold2;
  logic [2:0] first_wd;
  logic [3:0] diff;
  logic [3:0] diff_mod;

  always_comb begin
    fold1 = 6'(dow_sum[2:0]) + 6'(dow_sum[5:3]) + 6'(dow_sum[8:6]) +
            6'(dow_sum[11:9]) + 6'(dow_sum[14:12]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    first_wd = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    diff     = {1'b0, first_wd} + 4'd7 - {1'b0, week_start};
    diff_mod = (diff >= 4'd7) ? diff - 4'd7 : diff;
    // Day 1 on the week start: a full leading row of the previous month.
    offset   = (diff_mod == 4'd0) ? 3'd7 : diff_mod[2:0];
  end

endmodule

/* sv/mgdl_cell_map.sv */
// Maps a grid cell to the day shown and the in-month flag.
module mgdl_cell_map (
  input  logic [5:0] cell_idx,
  input  logic [2:0] offset,
  input  logic [4:0] len,
  input  logic [4:0] prev_len,
  output logic [4:0] day,
  output logic       in_month
);

  logic [6:0] c7;
  logic [6:0] o7;
  logic [6:0] end7;
  logic [6:0] day7;

  always_comb begin
    c7   = 7'(cell_idx);
    o7   = 7'(offset);
    end7 = o7 + 7'(len);
    in_month = 1'b0;
    priority if (c7 >= 7'(mgdl_pkg::GridCells)) begin
      day7 = 7'd0;
    end else if (c7 < o7) begin
      day7 = 7'(prev_len) + c7 + 7'd1 - o7;
    end else if (c7 >= end7) begin
      day7 = c7 - end7 + 7'd1;
    end else begin
      day7     = c7 - o7 + 7'd1;
      in_month = 1'b1;
    end
    day = day7[4:0];
  end

endmodule

/* sv/month_grid_day_lookup_top.sv */
// Month grid day lookup: top level with the four-stage request pipeline.
// Throughput: one request per cycle; the pipeline stalls only when out_ready holds it.
// Stages: year/100 multiply, month info and weekday sum, mod-7 offset, cell mapping.
// Reset (rst_n low, synchronous): pipeline emptied, month 1, year 2000, week start 1.
module month_grid_day_lookup_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [5:0]                    in_cell_index,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_day_number,
  output logic                          out_in_shown_month,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [mgdl_pkg::CfgDataW-1:0] cfg_wdata
);

  mgdl_pkg::cfg_t cfg;

  // The user must see that configuration only changes while no request is in flight;
  // the block does not enforce this, and every stage reads the live configuration.
  mgdl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // ---------------- handshake / advance chain ----------------
  logic adv_a, adv_b, adv_c, adv_out;
  logic va_r, vb_r, vc_r, out_valid_r;
  logic va_nxt, vb_nxt, vc_nxt, out_valid_nxt;

  assign adv_out  = !out_valid_r || out_ready;
  assign adv_c    = !vc_r || adv_out;
  assign adv_b    = !vb_r || adv_c;
  assign adv_a    = !va_r || adv_b;
  assign in_ready = adv_a;

  assign va_nxt        = adv_a   ? in_valid : va_r;
  assign vb_nxt        = adv_b   ? va_r     : vb_r;
  assign vc_nxt        = adv_c   ? vb_r     : vc_r;
  assign out_valid_nxt = adv_out ? vc_r     : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      vc_r        <= vc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- stage a: request capture, year / 100 ----------------
  logic [7:0] q100;
  logic [5:0] a_cell_r;
  logic [7:0] a_q100_r;

  mgdl_century_div u_cdiv (
    .year (cfg.year),
    .q100 (q100)
  );

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_cell_r <= in_cell_index;
      a_q100_r <= q100;
    end
  end

  // ---------------- stage b: lengths and weekday sum ----------------
  mgdl_pkg::month_info_t info;
  mgdl_pkg::month_info_t b_info_r;
  logic [5:0]            b_cell_r;

  mgdl_month_info u_minfo (
    .cfg  (cfg),
    .q100 (a_q100_r),
    .info (info)
  );

  always_ff @(posedge clk) begin
    if (adv_b) begin
      b_cell_r <= a_cell_r;
      b_info_r <= info;
    end
  end

  // ---------------- stage c: leading offset ----------------
  logic [2:0] offset;
  logic [5:0] c_cell_r;
  logic [2:0] c_off_r;
  logic [4:0] c_len_r;
  logic [4:0] c_prev_r;

  mgdl_lead_offset u_off (
    .dow_sum    (b_info_r.dow_sum),
    .week_start (cfg.week_start),
    .offset     (offset)
  );

  always_ff @(posedge clk) begin
    if (adv_c) begin
      c_cell_r <= b_cell_r;
      c_off_r  <= offset;
      c_len_r  <= b_info_r.len;
      c_prev_r <= b_info_r.prev_len;
    end
  end

  // ---------------- output register: cell mapping ----------------
  logic [4:0] day;
  logic       in_month;
  logic [4:0] out_day_r;
  logic       out_inside_r;

  mgdl_cell_map u_map (
    .cell_idx (c_cell_r),
    .offset   (c_off_r),
    .len      (c_len_r),
    .prev_len (c_prev_r),
    .day      (day),
    .in_month (in_month)
  );

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_day_r    <= day;
      out_inside_r <= in_month;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_day_number     = out_day_r;
  assign out_in_shown_month = out_inside_r;

  // ---------------- assertions ----------------
  // An empty output register means the whole pipeline can move.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with an empty output register");

  // A day inside the shown month is never zero.
  a_inside_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_shown_month) |-> (out_day_number != 5'd0))
    else $error("in-month result with day zero");

  // A stalled stage-a request keeps its cell.
  a_stage_a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !adv_b) |=> (va_r && $stable(a_cell_r)))
    else $error("stage a lost its request during a stall");

endmodule

/* tb/sv/month_grid_tb_pkg.sv */
// Scoreboard for the month grid day lookup: grid predictor and pending result queue.
package month_grid_tb_pkg;

  import mgdl_pkg::*;

  typedef struct packed {
    logic [4:0] day;
    logic       in_month;
  } grid_entry_t;

  class day_lookup_scoreboard;

    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  week_start;
    grid_entry_t pending[$];
    int          errors;
    int          checked;

    function new();
      month      = 4'd1;
      year       = 14'd2000;
      week_start = 3'd1;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [13:0] value);
      case (idx)
        REG_SHOWN_MONTH: month      = value[3:0];
        REG_SHOWN_YEAR:  year       = value;
        REG_WEEK_START:  week_start = value[2:0];
        default: ;
      endcase
    endfunction

    function bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function int unsigned days_in(int unsigned m, int unsigned y);
      int unsigned n;
      case (m)
        2:             n = is_leap(y) ? 29 : 28;
        4, 6, 9, 11:   n = 30;
        default:       n = 31;
      endcase
      return n;
    endfunction

    // Sakamoto-style month bias for the weekday of the 1st.
    function int unsigned month_bias(int unsigned m);
      int unsigned b;
      case (m)
        2, 6:    b = 3;
        3, 11:   b = 2;
        4, 7:    b = 5;
        8:       b = 1;
        9, 12:   b = 4;
        10:      b = 6;
        default: b = 0;
      endcase
      return b;
    endfunction

    function grid_entry_t lookup(logic [5:0] cell_idx);
      int unsigned m, ws, yy, wd, off, len, prev, c;
      grid_entry_t e;
      m  = month;
      ws = week_start % 7;
      c  = cell_idx;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      // extra 400 years keeps the Jan/Feb year-1 shift nonnegative
      yy   = year + 400 - ((m < 3) ? 1 : 0);
      wd   = (yy + yy / 4 - yy / 100 + yy / 400 + month_bias(m) + 1) % 7;
      off  = (wd + 7 - ws) % 7;
      if (off == 0) off = 7;
      len  = days_in(m, year);
      prev = (m == 1) ? 31 : days_in(m - 1, year);
      e.in_month = 1'b0;
      if (c >= 42) begin
        e.day = 5'd0;
      end else if (c < off) begin
        e.day = 5'(prev - (off - c) + 1);
      end else if (c >= off + len) begin
        e.day = 5'(c - (off + len) + 1);
      end else begin
        e.day      = 5'(c - off + 1);
        e.in_month = 1'b1;
      end
      return e;
    endfunction

    function void note_request(logic [5:0] cell_idx);
      pending.push_back(lookup(cell_idx));
    endfunction

    function void check_result(logic [4:0] day, logic in_month, time stamp);
      grid_entry_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none pending, day_number %0d in_shown_month %0b",
                 stamp, day, in_month);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (day !== want.day) begin
        $display("%0t: day_number mismatch, expected %0d, actual %0d", stamp, want.day, day);
        errors++;
      end
      if (in_month !== want.in_month) begin
        $display("%0t: in_shown_month mismatch, expected %0b, actual %0b",
                 stamp, want.in_month, in_month);
        errors++;
      end
    endfunction

  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top of the month grid day lookup testbench: clock, reset, drivers and run control.
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import mgdl_pkg::*;
  import month_grid_tb_pkg::*;

  localparam int PipeDepth   = 3;        // request to result
  localparam int RandomItems = 1650;
  localparam int CycleLimit  = 1000000;

  logic                clk                = 1'b0;
  logic                rst_n              = 1'b0;
  logic                in_valid           = 1'b0;
  logic                in_ready;
  logic [5:0]          in_cell_index      = '0;
  logic                out_valid;
  logic                out_ready          = 1'b0;
  logic [4:0]          out_day_number;
  logic                out_in_shown_month;
  logic                cfg_we             = 1'b0;
  logic [1:0]          cfg_index          = '0;
  logic [CfgDataW-1:0] cfg_wdata          = '0;

  day_lookup_scoreboard sb = new();

  int sent        = 0;
  int settings    = 0;
  int cycle_count = 0;
  // per-phase switches: when set, that side never idles
  bit calm_in     = 1'b0;
  bit calm_out    = 1'b0;

  month_grid_day_lookup_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cell_index      (in_cell_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_day_number     (out_day_number),
    .out_in_shown_month (out_in_shown_month),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Watchdog: a run that hangs on a handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly legal grid cells; the rest range over 0 to 63 and can reach past the grid.
  function automatic logic [5:0] pick_cell();
    if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, 41));
    return 6'($urandom_range(0, 63));
  endfunction

  // One request: optional idle gap, then hold valid until the block takes it.
  // Called and returns at a rising edge; valid is left high for back-to-back requests.
  task automatic send_cell(input logic [5:0] cell_idx);
    int gap;
    gap = calm_in ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_index <= cell_idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(cell_idx);
    sent++;
  endtask

  // Drop valid, let every pending result come back, then let the pipe settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth) @(posedge clk);
  endtask

  // Register writes happen only with the pipe empty. mask bit i selects register i.
  task automatic apply_setting(input logic [3:0] month, input logic [13:0] year,
                               input logic [2:0] week_start, input logic [2:0] mask);
    cfg_idx_t            regs [3];
    logic [CfgDataW-1:0] vals [3];
    regs = '{REG_SHOWN_MONTH, REG_SHOWN_YEAR, REG_WEEK_START};
    vals = '{CfgDataW'(month), year, CfgDataW'(week_start)};
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      if (mask[i]) begin
        // we stays high across consecutive writes
        cfg_we    <= 1'b1;
        cfg_index <= regs[i];
        cfg_wdata <= vals[i];
        @(posedge clk);
        sb.set_reg(regs[i], vals[i]);
      end
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Result side: random back-pressure, check each accepted result in order.
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      gap = calm_out ? 0 : pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_day_number, out_in_shown_month, $time);
    end
  end

  initial begin : stimulus
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  week_start;
    logic [2:0]  mask;
    int          r;
    int          count;
    bit          first;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // Reset setting: Jan 2000, Monday start, so the 1st sits at cell 5.
    // Covers both grid ends and cells past the grid.
    settings++;
    send_cell(6'd0);
    send_cell(6'd4);
    send_cell(6'd5);
    send_cell(6'd41);
    send_cell(6'd42);
    send_cell(6'd63);

    // Month zero reads as January, year zero is leap, week start 7 wraps to Sunday.
    apply_setting(4'd0, 14'd0, 3'd7, 3'b111);
    send_cell(6'd0);
    send_cell(6'd20);
    send_cell(6'd41);

    // Month 15 clamps to December; largest year the register holds; Sunday start.
    apply_setting(4'd15, 14'd16383, 3'd0, 3'b111);
    send_cell(6'd0);
    send_cell(6'd40);

    // Leap February 2000 starts on a Tuesday: with a Tuesday start the offset is
    // a full week, and day 29 is followed by a trailing 1.
    apply_setting(4'd2, 14'd2000, 3'd2, 3'b111);
    send_cell(6'd6);
    send_cell(6'd7);
    send_cell(6'd35);
    send_cell(6'd36);

    // January of year one: previous month is December, 31 days.
    apply_setting(4'd1, 14'd1, 3'd6, 3'b111);
    send_cell(6'd0);
    send_cell(6'd3);

    // Month 13 clamps to December; top of the legal year range.
    apply_setting(4'd13, 14'd9999, 3'd3, 3'b111);
    send_cell(6'd1);
    send_cell(6'd41);

    // March 1900: century year is not leap, so the leading tail ends at 28.
    apply_setting(4'd3, 14'd1900, 3'd0, 3'b111);
    send_cell(6'd0);
    send_cell(6'd1);

    // --- random part ---
    count = sent;
    first = 1'b1;
    while (sent < count + RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 85) month = 4'($urandom_range(1, 12));
      else        month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
      r = $urandom_range(0, 99);
      if (r < 60)      year = 14'($urandom_range(1, 9999));
      else if (r < 85) year = 14'($urandom_range(0, 16383));
      else if (r < 92) year = 14'($urandom_range(0, 1));
      else             year = ($urandom_range(0, 1) == 0) ? 14'd16383 : 14'd9999;
      week_start = 3'($urandom_range(0, 7));
      mask       = first ? 3'b111 : 3'($urandom_range(0, 7));
      first      = 1'b0;
      apply_setting(month, year, week_start, mask);
      calm_in  = ($urandom_range(0, 99) < 20);
      calm_out = ($urandom_range(0, 99) < 20);
      repeat ($urandom_range(20, 80)) send_cell(pick_cell());
    end

    // --- drain and report ---
    wait_drained();
    repeat (2 * PipeDepth) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    $display("Ran %0d cell requests over %0d register settings, %0d results checked.",
             sent, settings, sb.checked);
    $display("Settings spanned clamped months, year 0 to 16383, all week starts incl. 7.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
